// ===== sv/gatt_robust_caching_gate_assert.svh =====
// assertion macros for the robust caching gate
`ifndef GATT_ROBUST_CACHING_GATE_ASSERT_SVH
`define GATT_ROBUST_CACHING_GATE_ASSERT_SVH

`ifndef SYNTHESIS
`define GRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("robust caching gate assertion failed");
`define GRC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("robust caching gate assertion failed");
`else
`define GRC_ASSERT(lbl, clk, rst, prop)
`define GRC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/gatt_rc_pkg.sv =====
package gatt_rc_pkg;

  typedef enum logic [2:0] {
    OP_ATT_PDU    = 3'd0,
    OP_HASH_READ  = 3'd1,
    OP_FEAT_WRITE = 3'd2,
    OP_IND_CONF   = 3'd3,
    OP_DB_CHANGED = 3'd4,
    OP_BOND_EST   = 3'd5,
    OP_BOND_REST  = 3'd6,
    OP_CONN_OPEN  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_OOS  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    BEARER_FIXED     = 2'd0,
    BEARER_FIXED_ECB = 2'd1,
    BEARER_ENHANCED  = 2'd2
  } bearer_e;

  typedef enum logic [1:0] {
    FORM_UUID16  = 2'd0,
    FORM_UUID128 = 2'd1
  } pdu_form_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ctrl_state_e;

  // att opcodes
  localparam logic [7:0] ATT_FIND_INFO_REQ    = 8'h04;
  localparam logic [7:0] ATT_READ_TYPE_REQ    = 8'h08;
  localparam logic [7:0] ATT_READ_REQ         = 8'h0A;
  localparam logic [7:0] ATT_READ_BLOB_REQ    = 8'h0C;
  localparam logic [7:0] ATT_READ_MULT_REQ    = 8'h0E;
  localparam logic [7:0] ATT_READ_MULT_VAR    = 8'h20;
  localparam logic [7:0] ATT_WRITE_REQ        = 8'h12;
  localparam logic [7:0] ATT_PREP_WRITE_REQ   = 8'h16;
  localparam logic [7:0] ATT_WRITE_CMD        = 8'h52;

  localparam logic [15:0] HANDLE_FIRST        = 16'h0001;
  localparam logic [15:0] HANDLE_LAST         = 16'hFFFF;
  localparam logic [15:0] UUID_INCLUDE        = 16'h2802;
  localparam logic [15:0] UUID_CHARACTERISTIC = 16'h2803;

  // flag bits
  localparam int FLAG_AWARE = 0;
  localparam int FLAG_HASH  = 1;
  localparam int FLAG_OOS   = 2;
  localparam int FEAT_ROBUST = 0;

  localparam logic [2:0] FLAGS_AWARE_ONLY = 3'b001;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  conn_slot;
    logic [7:0]  att_opcode;
    logic [1:0]  bearer;
    logic        bonded;
    logic [1:0]  pdu_form;
    logic [15:0] start_handle;
    logic [15:0] end_handle;
    logic [15:0] type_uuid16;
    logic        is_service_changed;
    logic [7:0]  feature_byte;
    logic        stored_change_aware;
  } req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       persist;
    logic       persist_change_aware;
    logic [7:0] persist_features;
    logic       mark_store_unaware;
    logic [2:0] slot_out;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== sv/gatt_rc_ctrl.sv =====
module gatt_rc_ctrl
  import gatt_rc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  ctrl_state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== sv/gatt_rc_dp.sv =====
module gatt_rc_dp
  import gatt_rc_pkg::*;
#(
  parameter int MAX_CONNECTIONS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  req_t      req,
  output rsp_t      rsp
);

  localparam int IdxW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;

  req_t       r;
  logic [7:0] features [MAX_CONNECTIONS];
  logic [2:0] flags    [MAX_CONNECTIONS];

  logic [IdxW-1:0] sidx;
  logic            valid;
  logic [7:0]      feat;
  logic [2:0]      flg;
  logic            robust_unaware;
  logic            is_req;
  logic            is_cmd;
  logic            exempt;
  logic            wr;
  logic            clear_all;
  logic [7:0]      feat_new;
  logic [2:0]      flg_new;
  logic [1:0]      verdict;
  logic            persist;
  logic            mark;
  logic [7:0]      feat_after;
  logic [2:0]      flg_after;

  always_ff @(posedge clk) begin
    if (cmd.capture) r <= req;
  end

  assign sidx  = IdxW'(r.conn_slot);
  assign valid = 32'(r.conn_slot) < 32'(MAX_CONNECTIONS);
  assign feat  = valid ? features[sidx] : 8'd0;
  assign flg   = valid ? flags[sidx] : 3'd0;
  assign robust_unaware = valid && feat[FEAT_ROBUST] && !flg[FLAG_AWARE];

  always_comb begin
    is_req = r.att_opcode inside {ATT_READ_TYPE_REQ, ATT_READ_REQ, ATT_READ_BLOB_REQ,
                                  ATT_READ_MULT_REQ, ATT_READ_MULT_VAR, ATT_WRITE_REQ,
                                  ATT_PREP_WRITE_REQ};
    is_cmd = (r.att_opcode == ATT_WRITE_CMD);
    exempt = !(r.pdu_form inside {FORM_UUID16, FORM_UUID128})
             || (r.start_handle == HANDLE_FIRST && r.end_handle == HANDLE_LAST)
             || (r.pdu_form == FORM_UUID16
                 && (r.type_uuid16 == UUID_INCLUDE
                     || r.type_uuid16 == UUID_CHARACTERISTIC));
  end

  always_comb begin
    wr        = 1'b0;
    clear_all = 1'b0;
    feat_new  = feat;
    flg_new   = flg;
    verdict   = VERDICT_PASS;
    persist   = 1'b0;
    mark      = 1'b0;
    case (r.op)
      OP_ATT_PDU: begin
        if ((is_req || is_cmd) && robust_unaware) begin
          if (is_cmd) begin
            verdict = VERDICT_DROP;
          end else if (flg[FLAG_HASH] || (flg[FLAG_OOS] && r.bearer == BEARER_FIXED)) begin
            wr      = 1'b1;
            flg_new = FLAGS_AWARE_ONLY;
            persist = r.bonded;
          end else if (r.att_opcode == ATT_READ_TYPE_REQ && exempt) begin
            verdict = VERDICT_PASS;
          end else if (r.bearer inside {BEARER_FIXED, BEARER_FIXED_ECB}) begin
            if (!flg[FLAG_OOS]) begin
              wr                = 1'b1;
              flg_new[FLAG_OOS] = 1'b1;
              verdict           = VERDICT_OOS;
            end else begin
              verdict = VERDICT_DROP;
            end
          end else begin
            verdict = VERDICT_OOS;
          end
        end
      end
      OP_HASH_READ: begin
        if (robust_unaware) begin
          wr                 = 1'b1;
          flg_new[FLAG_HASH] = 1'b1;
        end
      end
      OP_FEAT_WRITE: begin
        if (valid) begin
          wr       = 1'b1;
          feat_new = feat | r.feature_byte;
          flg_new  = FLAGS_AWARE_ONLY;
          persist  = r.bonded;
        end
      end
      OP_IND_CONF: begin
        if (r.is_service_changed && r.bearer == BEARER_FIXED && robust_unaware) begin
          wr      = 1'b1;
          flg_new = FLAGS_AWARE_ONLY;
          persist = r.bonded;
        end
      end
      OP_DB_CHANGED: begin
        clear_all = 1'b1;
        mark      = 1'b1;
      end
      OP_BOND_EST: begin
        if (valid && feat != 8'd0) persist = r.bonded;
      end
      OP_BOND_REST: begin
        if (valid) begin
          wr = 1'b1;
          if (feat == 8'd0) flg_new = r.stored_change_aware ? FLAGS_AWARE_ONLY : 3'd0;
          feat_new = feat | r.feature_byte;
        end
      end
      OP_CONN_OPEN: begin
        if (valid) begin
          wr       = 1'b1;
          feat_new = 8'd0;
          flg_new  = 3'd0;
        end
      end
      default: verdict = VERDICT_PASS;
    endcase
  end

  assign feat_after = wr ? feat_new : feat;
  assign flg_after  = wr ? flg_new : flg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CONNECTIONS; i++) begin
        features[i] <= 8'd0;
        flags[i]    <= 3'd0;
      end
    end else if (cmd.exec) begin
      if (clear_all) begin
        for (int i = 0; i < MAX_CONNECTIONS; i++) begin
          flags[i] <= 3'd0;
        end
      end else if (wr) begin
        features[sidx] <= feat_new;
        flags[sidx]    <= flg_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.verdict              <= verdict;
      rsp.persist              <= persist;
      rsp.persist_change_aware <= persist && flg_after[FLAG_AWARE];
      rsp.persist_features     <= persist ? feat_after : 8'd0;
      rsp.mark_store_unaware   <= mark;
      rsp.slot_out             <= r.conn_slot;
    end
  end

endmodule

// ===== sv/gatt_robust_caching_gate.sv =====
// accepted requests are captured, executed in ST_EXEC, answered with done in ST_DONE
// no new request is taken until the last has left the execute and result states
// busy stays high from acceptance until the result cycle ends; the receiver cannot stall
// reset (rst, synchronous) clears every slot's features byte and flags and returns to idle
`include "gatt_robust_caching_gate_assert.svh"
module gatt_robust_caching_gate
  import gatt_rc_pkg::*;
#(
  parameter int MAX_CONNECTIONS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  ctrl_cmd_t cmd;

  gatt_rc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  gatt_rc_dp #(
    .MAX_CONNECTIONS (MAX_CONNECTIONS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  `GRC_ASSERT(a_result_follows, clk, rst, (start && !busy) |-> ##2 (done && rsp.slot_out == $past(req.conn_slot, 2)))
  `GRC_ASSERT(a_done_single, clk, rst, done |=> !done)
  `GRC_ASSERT_IMPL(a_no_persist_zero, clk, rst, done && !rsp.persist, !rsp.persist_change_aware && rsp.persist_features == 8'd0)
  `GRC_ASSERT_IMPL(a_mark_passes, clk, rst, done && rsp.mark_store_unaware, rsp.verdict == VERDICT_PASS && !rsp.persist)

endmodule

// ===== test/tb_gatt_robust_caching_gate.sv =====
module tb_gatt_robust_caching_gate;
  import gatt_rc_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int NUM_EVENTS = 900;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  req_t event_q[$];
  rsp_t due_rsp_q[$];
  rsp_t exp_rsp;
  logic [7:0] feat_mem [NUM_SLOTS];
  logic [2:0] flag_mem [NUM_SLOTS];
  int total_events = NUM_EVENTS;
  int n_accepted = 0;
  int err_count = 0;
  int cycle_count = 0;
  int idle_pct;

  gatt_robust_caching_gate #(
    .MAX_CONNECTIONS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic read_type_exempt(req_t r);
    if (r.pdu_form != FORM_UUID16 && r.pdu_form != FORM_UUID128) return 1'b1;
    if (r.start_handle == HANDLE_FIRST && r.end_handle == HANDLE_LAST) return 1'b1;
    if (r.pdu_form == FORM_UUID16 &&
        (r.type_uuid16 == UUID_INCLUDE || r.type_uuid16 == UUID_CHARACTERISTIC))
      return 1'b1;
    return 1'b0;
  endfunction

  // updates the per-slot caching state and returns the gate decision
  function automatic rsp_t gate_decision(req_t r);
    rsp_t o;
    logic [2:0] s;
    logic unaware;
    logic is_req;
    logic is_cmd;
    s = r.conn_slot;
    o = '0;
    o.slot_out = s;
    o.verdict = VERDICT_PASS;
    unaware = feat_mem[s][FEAT_ROBUST] && !flag_mem[s][FLAG_AWARE];
    case (r.op)
      OP_ATT_PDU: begin
        is_req = r.att_opcode == ATT_READ_TYPE_REQ || r.att_opcode == ATT_READ_REQ ||
                 r.att_opcode == ATT_READ_BLOB_REQ || r.att_opcode == ATT_READ_MULT_REQ ||
                 r.att_opcode == ATT_READ_MULT_VAR || r.att_opcode == ATT_WRITE_REQ ||
                 r.att_opcode == ATT_PREP_WRITE_REQ;
        is_cmd = r.att_opcode == ATT_WRITE_CMD;
        if ((is_req || is_cmd) && unaware) begin
          if (is_cmd) begin
            o.verdict = VERDICT_DROP;
          end else if (flag_mem[s][FLAG_HASH] ||
                       (flag_mem[s][FLAG_OOS] && r.bearer == BEARER_FIXED)) begin
            flag_mem[s] = FLAGS_AWARE_ONLY;
            o.persist = r.bonded;
          end else if (r.att_opcode == ATT_READ_TYPE_REQ && read_type_exempt(r)) begin
            o.verdict = VERDICT_PASS;
          end else if (r.bearer <= BEARER_FIXED_ECB) begin
            if (!flag_mem[s][FLAG_OOS]) begin
              flag_mem[s][FLAG_OOS] = 1'b1;
              o.verdict = VERDICT_OOS;
            end else begin
              o.verdict = VERDICT_DROP;
            end
          end else begin
            o.verdict = VERDICT_OOS;
          end
        end
      end
      OP_HASH_READ: begin
        if (unaware) flag_mem[s][FLAG_HASH] = 1'b1;
      end
      OP_FEAT_WRITE: begin
        feat_mem[s] = feat_mem[s] | r.feature_byte;
        flag_mem[s] = FLAGS_AWARE_ONLY;
        o.persist = r.bonded;
      end
      OP_IND_CONF: begin
        if (r.is_service_changed && r.bearer == BEARER_FIXED && unaware) begin
          flag_mem[s] = FLAGS_AWARE_ONLY;
          o.persist = r.bonded;
        end
      end
      OP_DB_CHANGED: begin
        for (int i = 0; i < NUM_SLOTS; i++) flag_mem[i] = '0;
        o.mark_store_unaware = 1'b1;
      end
      OP_BOND_EST: begin
        if (feat_mem[s] != 8'h00) o.persist = r.bonded;
      end
      OP_BOND_REST: begin
        if (feat_mem[s] == 8'h00)
          flag_mem[s] = r.stored_change_aware ? FLAGS_AWARE_ONLY : 3'b000;
        feat_mem[s] = feat_mem[s] | r.feature_byte;
      end
      default: begin
        feat_mem[s] = '0;
        flag_mem[s] = '0;
      end
    endcase
    if (o.persist) begin
      o.persist_change_aware = flag_mem[s][FLAG_AWARE];
      o.persist_features = feat_mem[s];
    end
    return o;
  endfunction

  function automatic req_t mk(logic [2:0] op, logic [2:0] slot, logic [7:0] att,
                              logic [1:0] bearer, logic bonded, logic [1:0] form,
                              logic [15:0] sh, logic [15:0] eh, logic [15:0] uuid,
                              logic sc, logic [7:0] fb, logic sca);
    req_t r;
    r.op = op;
    r.conn_slot = slot;
    r.att_opcode = att;
    r.bearer = bearer;
    r.bonded = bonded;
    r.pdu_form = form;
    r.start_handle = sh;
    r.end_handle = eh;
    r.type_uuid16 = uuid;
    r.is_service_changed = sc;
    r.feature_byte = fb;
    r.stored_change_aware = sca;
    return r;
  endfunction

  function automatic logic [7:0] pick_att();
    case ($urandom_range(0, 10))
      0: return ATT_READ_TYPE_REQ;
      1: return ATT_READ_TYPE_REQ;
      2: return ATT_READ_REQ;
      3: return ATT_READ_BLOB_REQ;
      4: return ATT_READ_MULT_REQ;
      5: return ATT_READ_MULT_VAR;
      6: return ATT_WRITE_REQ;
      7: return ATT_PREP_WRITE_REQ;
      8: return ATT_WRITE_CMD;
      9: return ATT_FIND_INFO_REQ;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // every field but the slot random, with handles and uuid leaning toward the read by type exemptions
  function automatic req_t random_event(logic [2:0] slot);
    req_t r;
    r.op = 3'($urandom_range(0, 7));
    r.conn_slot = slot;
    r.att_opcode = 8'($urandom_range(0, 255));
    r.bearer = 2'($urandom_range(0, 3));
    r.bonded = 1'($urandom_range(0, 1));
    r.pdu_form = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
    r.start_handle = ($urandom_range(0, 2) == 0) ? HANDLE_FIRST : 16'($urandom_range(0, 65535));
    r.end_handle = ($urandom_range(0, 2) == 0) ? HANDLE_LAST : 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: r.type_uuid16 = UUID_INCLUDE;
      1: r.type_uuid16 = UUID_CHARACTERISTIC;
      default: r.type_uuid16 = 16'($urandom_range(0, 65535));
    endcase
    r.is_service_changed = 1'($urandom_range(0, 1));
    r.feature_byte = 8'($urandom_range(0, 255));
    r.stored_change_aware = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // connection setup, optional db change, then a run of events, mostly att traffic on one slot
  task automatic push_session();
    req_t r;
    logic [2:0] slot;
    int len;
    slot = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 0) begin
      r = random_event(slot);
      r.op = OP_CONN_OPEN;
      event_q.push_back(r);
    end
    r = random_event(slot);
    r.op = ($urandom_range(0, 2) == 0) ? OP_BOND_REST : OP_FEAT_WRITE;
    if ($urandom_range(0, 4) != 0) r.feature_byte[FEAT_ROBUST] = 1'b1;
    event_q.push_back(r);
    if ($urandom_range(0, 3) != 0) begin
      r = random_event(3'($urandom_range(0, 7)));
      r.op = OP_DB_CHANGED;
      event_q.push_back(r);
    end
    len = $urandom_range(2, 10);
    for (int k = 0; k < len; k++) begin
      r = random_event(slot);
      case ($urandom_range(0, 19))
        0, 1: r.op = OP_HASH_READ;
        2, 3: begin
          r.op = OP_IND_CONF;
          if ($urandom_range(0, 1) == 0) r.bearer = BEARER_FIXED;
        end
        4: r.op = OP_BOND_EST;
        5: r.op = OP_DB_CHANGED;
        6: r.conn_slot = 3'($urandom_range(0, 7));
        default: begin
          r.op = OP_ATT_PDU;
          r.att_opcode = pick_att();
        end
      endcase
      event_q.push_back(r);
    end
  endtask

  initial begin
    event_q.push_back(mk(OP_CONN_OPEN, 3'd0, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_FEAT_WRITE, 3'd0, 8'h00, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h01, 1'b0));
    event_q.push_back(mk(OP_DB_CHANGED, 3'd0, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_REQ, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_REQ, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_DB_CHANGED, 3'd5, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_WRITE_CMD, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_TYPE_REQ, BEARER_FIXED, 1'b1, FORM_UUID16,
                         HANDLE_FIRST, HANDLE_LAST, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_TYPE_REQ, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, UUID_INCLUDE, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_TYPE_REQ, BEARER_FIXED_ECB, 1'b1,
                         FORM_UUID128, 16'h0002, 16'h0003, UUID_CHARACTERISTIC, 1'b0,
                         8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_REQ, BEARER_FIXED_ECB, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_WRITE_REQ, BEARER_ENHANCED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_PREP_WRITE_REQ, 2'd3, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_IND_CONF, 3'd0, 8'h00, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0));
    event_q.push_back(mk(OP_DB_CHANGED, 3'd7, 8'hFF, 2'd3, 1'b1, 2'd3,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_TYPE_REQ, BEARER_FIXED, 1'b1, 2'd3,
                         16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_HASH_READ, 3'd0, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd0, ATT_READ_MULT_VAR, BEARER_ENHANCED, 1'b0,
                         FORM_UUID16, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_BOND_EST, 3'd0, 8'h00, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_BOND_REST, 3'd1, 8'h00, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'hFF, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd1, 8'hFF, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_ATT_PDU, 3'd1, ATT_READ_BLOB_REQ, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_FEAT_WRITE, 3'd7, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'hFE, 1'b0));
    event_q.push_back(mk(OP_CONN_OPEN, 3'd1, 8'h00, BEARER_FIXED, 1'b0, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0));
    event_q.push_back(mk(OP_BOND_REST, 3'd1, 8'h00, BEARER_FIXED, 1'b1, FORM_UUID16,
                         16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h01, 1'b1));

    // mostly sessions, some pure noise
    while (event_q.size() < NUM_EVENTS) begin
      if ($urandom_range(0, 5) == 0) event_q.push_back(random_event(3'($urandom_range(0, 7))));
      else push_session();
    end
    total_events = event_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_events || due_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      feat_mem[i] = '0;
      flag_mem[i] = '0;
    end
  end

  // sender idle rate by thirds of the run
  always_comb begin
    if (n_accepted < total_events / 3) idle_pct = 38;
    else if (n_accepted < 2 * total_events / 3) idle_pct = 88;
    else idle_pct = 0;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        due_rsp_q.push_back(gate_decision(req));
        n_accepted <= n_accepted + 1;
      end
      if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        req <= event_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (due_rsp_q.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < MAX_REPORTS)
          $display("unexpected result: slot %0d verdict %0d", rsp.slot_out, rsp.verdict);
      end else begin
        exp_rsp = due_rsp_q.pop_front();
        if (rsp.verdict !== exp_rsp.verdict || rsp.persist !== exp_rsp.persist ||
            rsp.persist_change_aware !== exp_rsp.persist_change_aware ||
            rsp.persist_features !== exp_rsp.persist_features ||
            rsp.mark_store_unaware !== exp_rsp.mark_store_unaware ||
            rsp.slot_out !== exp_rsp.slot_out) begin
          err_count <= err_count + 1;
          if (err_count < MAX_REPORTS)
            $display("mismatch: exp v%0d p%0d a%0d f%h m%0d s%0d got v%0d p%0d a%0d f%h m%0d s%0d",
                     exp_rsp.verdict, exp_rsp.persist, exp_rsp.persist_change_aware,
                     exp_rsp.persist_features, exp_rsp.mark_store_unaware, exp_rsp.slot_out,
                     rsp.verdict, rsp.persist, rsp.persist_change_aware,
                     rsp.persist_features, rsp.mark_store_unaware, rsp.slot_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
